/* hw/rtl/nwpt_pkg.sv */
package nwpt_pkg;

  // Fine timer width; every phase and wait value wraps at this width.
  localparam int FINE_BITS = 16;

  // Defaults for the top-level parameters.
  localparam int NEIGHBORS_DEF  = 16;
  localparam int POOL_SLOTS_DEF = 8;

  // Clock rates used to convert fine ticks into coarse ticks.
  // Both rates are powers of two, so the conversion is a multiply and a shift.
  localparam int COARSE_RATE = 128;
  localparam int FINE_RATE   = 32768;
  localparam int FINE_SHIFT  = $clog2(FINE_RATE);

  // Field widths of the stream items.
  localparam int MODE_W    = 2;
  localparam int INDEX_W   = 4;
  localparam int STATUS_W  = 2;
  localparam int COARSE_W  = 32;
  localparam int COUNT_W   = 3;
  localparam int VERDICT_W = 3;
  localparam int S_DATA_W  = 72;
  localparam int M_DATA_W  = 32;

  // Request modes.
  localparam logic [MODE_W-1:0] MODE_REPORT  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_QUERY   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_RELEASE = 2'd2;

  // Transmit outcomes.
  localparam logic [STATUS_W-1:0] TX_ACKED = 2'd0;
  localparam logic [STATUS_W-1:0] TX_NOACK = 2'd1;

  // Result verdicts.
  localparam logic [VERDICT_W-1:0] VERDICT_UNKNOWN  = 3'd0;
  localparam logic [VERDICT_W-1:0] VERDICT_DEFERRED = 3'd1;
  localparam logic [VERDICT_W-1:0] VERDICT_SEND_NOW = 3'd2;
  localparam logic [VERDICT_W-1:0] VERDICT_UPDATED  = 3'd3;
  localparam logic [VERDICT_W-1:0] VERDICT_DROPPED  = 3'd4;

  // Configuration register indexes.
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 16;
  localparam logic [CFG_INDEX_W-1:0] REG_CYCLE_LENGTH    = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_GUARD_TICKS     = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_DEFER_THRESHOLD = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_NOACK_LIMIT     = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_NOACK_WINDOW    = 3'd4;

  // Configuration reset values.
  localparam logic [15:0]        CYCLE_LENGTH_RST    = 16'd4096;
  localparam logic [15:0]        GUARD_TICKS_RST     = 16'd16;
  localparam logic [7:0]         DEFER_THRESHOLD_RST = 8'd1;
  localparam logic [COUNT_W-1:0] NOACK_LIMIT_RST     = 3'd4;
  localparam logic [15:0]        NOACK_WINDOW_RST    = 16'd7680;

  // Miss counter saturation value.
  localparam logic [COUNT_W-1:0] COUNT_MAX = 3'd7;

  // One neighbor entry as held in the table memory.
  typedef struct packed {
    logic [FINE_BITS-1:0] stamp;
    logic [COUNT_W-1:0]   miss_count;
    logic [COARSE_W-1:0]  window_start;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage

/* hw/rtl/neighbor_wakeup_phase_table_unit.sv */
// Neighbor wake-up phase table for a duty-cycled radio MAC.
// Requests arrive on the s_ channel: a transmit report (mode 0) updates or
// creates a neighbor's phase entry or counts a missed ack, a send-time query
// (mode 1) returns the wait to the neighbor's next wake-up, and a release
// (mode 2) frees a deferral pool slot. Each request yields exactly one result
// transfer on the m_ channel. Configuration writes on the cfg_ channel are
// always accepted and must only be issued while no request is in flight.
// One request is processed at a time. After accept the entry is read; then
// releases, ignored requests and acked reports load the result, a missed ack
// passes the drop check first, and a query passes the adjust and decide
// steps, for a cycle length that is not a power of two after the bit-serial
// modulo unit, which works out one remainder bit at a time. The next request
// can be accepted in the cycle after the result is loaded. The entry memory is
// read in the cycle after accept and written back once the update is known.
// Reset clears all entry valid flags and the pool count and loads the
// configuration defaults; the entry memory itself is not cleared. When the
// receiver stalls, the result is held in the output register and the next
// request is still accepted, but its result waits until the held one has
// been transferred.
module neighbor_wakeup_phase_table_unit #(
  parameter int NEIGHBORS  = nwpt_pkg::NEIGHBORS_DEF,
  parameter int POOL_SLOTS = nwpt_pkg::POOL_SLOTS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  // neighbor_index[3:0], tx_status[5:4], event_time[21:6], fine_now[37:22],
  // coarse_now[69:38], already_deferred[70], zero fill [71]
  input  logic [nwpt_pkg::S_DATA_W-1:0]      s_tdata,
  // mode[1:0]
  input  logic [nwpt_pkg::MODE_W-1:0]        s_tuser,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  // defer_ticks[15:0], expected_time[31:16]
  output logic [nwpt_pkg::M_DATA_W-1:0]      m_tdata,
  // verdict[2:0]
  output logic [nwpt_pkg::VERDICT_W-1:0]     m_tuser,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [nwpt_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [nwpt_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int FW     = nwpt_pkg::FINE_BITS;
  localparam int AW     = (NEIGHBORS > 1) ? $clog2(NEIGHBORS) : 1;
  localparam int SLOT_W = $clog2(POOL_SLOTS + 1);
  localparam int PROD_W = FW + $clog2(nwpt_pkg::COARSE_RATE + 1);

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_READ   = 7'b0000010,
    S_REPORT = 7'b0000100,
    S_DIVIDE = 7'b0001000,
    S_ADJUST = 7'b0010000,
    S_DECIDE = 7'b0100000,
    S_RESULT = 7'b1000000
  } state_t;

  state_t state;

  // Configuration registers.
  logic [FW-1:0]                  cycle_length;
  logic [FW-1:0]                  guard_ticks;
  logic [7:0]                     defer_threshold;
  logic [nwpt_pkg::COUNT_W-1:0]   noack_limit;
  logic [15:0]                    noack_window;

  // Latched request.
  logic [nwpt_pkg::MODE_W-1:0]    mode_q;
  logic [AW-1:0]                  addr_q;
  logic                           in_range_q;
  logic [nwpt_pkg::STATUS_W-1:0]  status_q;
  logic [FW-1:0]                  event_q;
  logic [FW-1:0]                  fine_q;
  logic [nwpt_pkg::COARSE_W-1:0]  coarse_q;
  logic                           deferred_q;

  // Table state.
  logic [NEIGHBORS-1:0]           entry_valid;
  logic [SLOT_W-1:0]              slots_in_use;
  nwpt_pkg::entry_t               rd_entry;
  nwpt_pkg::entry_t               upd_entry;
  nwpt_pkg::entry_t               miss_entry;
  nwpt_pkg::entry_t               ram_wdata;
  logic                           ram_we;

  // Query working values.
  logic [FW-1:0]                  wait_q;
  logic                           div_start;
  logic                           div_done;
  logic [FW-1:0]                  div_rem;

  // Result staging and output register.
  logic [nwpt_pkg::VERDICT_W-1:0] res_verdict;
  logic [FW-1:0]                  res_defer;
  logic [FW-1:0]                  res_expected;
  logic [FW-1:0]                  out_defer;
  logic [FW-1:0]                  out_expected;

  // Combinational helpers.
  logic                           s_xfer;
  logic                           out_free;
  logic                           cyc_pow2;
  logic [FW-1:0]                  cyc_mask;
  logic [FW-1:0]                  fine_diff;
  logic                           cur_valid;
  logic [nwpt_pkg::COUNT_W-1:0]   cnt_inc;
  logic [nwpt_pkg::COARSE_W-1:0]  ws_new;
  logic [nwpt_pkg::COARSE_W-1:0]  window_age;
  logic                           drop;
  logic [FW-1:0]                  rest;
  logic [PROD_W-1:0]              coarse_prod;
  logic [PROD_W-1:0]              coarse_shift;
  logic [FW-1:0]                  coarse_ticks;
  logic                           want_defer;

  assign s_tready  = (state == S_IDLE);
  assign s_xfer    = s_tvalid && s_tready;
  assign cfg_ready = 1'b1;
  assign out_free  = !m_tvalid || m_tready;
  assign m_tdata   = {out_expected, out_defer};

  // Configuration writes; unknown indexes are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      cycle_length    <= nwpt_pkg::CYCLE_LENGTH_RST;
      guard_ticks     <= nwpt_pkg::GUARD_TICKS_RST;
      defer_threshold <= nwpt_pkg::DEFER_THRESHOLD_RST;
      noack_limit     <= nwpt_pkg::NOACK_LIMIT_RST;
      noack_window    <= nwpt_pkg::NOACK_WINDOW_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        nwpt_pkg::REG_CYCLE_LENGTH:    cycle_length    <= cfg_data;
        nwpt_pkg::REG_GUARD_TICKS:     guard_ticks     <= cfg_data;
        nwpt_pkg::REG_DEFER_THRESHOLD: defer_threshold <= cfg_data[7:0];
        nwpt_pkg::REG_NOACK_LIMIT:     noack_limit     <= cfg_data[nwpt_pkg::COUNT_W-1:0];
        nwpt_pkg::REG_NOACK_WINDOW:    noack_window    <= cfg_data;
        default: ;
      endcase
    end
  end

  // Entry memory: phase stamp, miss count and window start per neighbor.
  nwpt_ram #(
    .WIDTH (nwpt_pkg::ENTRY_W),
    .DEPTH (NEIGHBORS)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (addr_q),
    .wdata (ram_wdata),
    .raddr (AW'(s_tdata[3:0])),
    .rdata (rd_entry)
  );

  // Bit-serial modulo for cycle lengths that are not a power of two.
  nwpt_mod u_mod (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (fine_diff),
    .divisor   (cycle_length),
    .done      (div_done),
    .remainder (div_rem)
  );

  // Phase arithmetic on the entry just read.
  always_comb begin
    cur_valid  = in_range_q && entry_valid[addr_q];
    cyc_mask   = cycle_length - 1'b1;
    cyc_pow2   = (cycle_length & cyc_mask) == '0;
    fine_diff  = fine_q - rd_entry.stamp;
    cnt_inc    = (rd_entry.miss_count < nwpt_pkg::COUNT_MAX) ?
                 rd_entry.miss_count + 1'b1 : nwpt_pkg::COUNT_MAX;
    ws_new     = (cnt_inc == nwpt_pkg::COUNT_W'(1)) ? coarse_q : rd_entry.window_start;
    upd_entry.stamp        = rd_entry.stamp;
    upd_entry.miss_count   = cnt_inc;
    upd_entry.window_start = ws_new;
    div_start  = (state == S_READ) && (mode_q == nwpt_pkg::MODE_QUERY) && cur_valid
                 && !cyc_pow2;
  end

  // Miss handling: drop on limit or on an expired window, using the entry
  // latched in the read cycle.
  always_comb begin
    window_age = coarse_q - miss_entry.window_start;
    drop       = (miss_entry.miss_count >= noack_limit)
                 || (window_age >= 32'(noack_window));
  end

  // Entry write-back.
  always_comb begin
    ram_we    = 1'b0;
    ram_wdata = miss_entry;
    if (state == S_READ && mode_q == nwpt_pkg::MODE_REPORT && in_range_q
        && status_q == nwpt_pkg::TX_ACKED) begin
      ram_we                 = 1'b1;
      ram_wdata.stamp        = event_q;
      ram_wdata.miss_count   = '0;
      ram_wdata.window_start = rd_entry.window_start;
    end else if (state == S_REPORT) begin
      ram_we = 1'b1;
    end
  end

  // Coarse conversion and the defer decision.
  always_comb begin
    rest         = (wait_q >= guard_ticks) ? wait_q - guard_ticks : '0;
    coarse_prod  = PROD_W'(rest) * PROD_W'(nwpt_pkg::COARSE_RATE);
    coarse_shift = coarse_prod >> nwpt_pkg::FINE_SHIFT;
    coarse_ticks = (coarse_shift > PROD_W'(16'hFFFF)) ? 16'hFFFF : coarse_shift[FW-1:0];
    want_defer   = (coarse_ticks > FW'(defer_threshold)) && !deferred_q;
  end

  // Sequencer and table state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      entry_valid  <= '0;
      slots_in_use <= '0;
      m_tvalid     <= 1'b0;
    end else begin
      // The output is valid from the load of a result until its transfer.
      if (state == S_RESULT && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (s_xfer) begin
            state <= S_READ;
          end
        end
        S_READ: begin
          unique case (mode_q)
            nwpt_pkg::MODE_RELEASE: begin
              state <= S_RESULT;
              if (slots_in_use != '0) begin
                slots_in_use <= slots_in_use - 1'b1;
              end
            end
            nwpt_pkg::MODE_REPORT: begin
              if (in_range_q && status_q == nwpt_pkg::TX_ACKED) begin
                entry_valid[addr_q] <= 1'b1;
              end
              if (cur_valid && status_q == nwpt_pkg::TX_NOACK) begin
                state <= S_REPORT;
              end else begin
                state <= S_RESULT;
              end
            end
            nwpt_pkg::MODE_QUERY: begin
              if (cur_valid) begin
                state <= cyc_pow2 ? S_ADJUST : S_DIVIDE;
              end else begin
                state <= S_RESULT;
              end
            end
            default: state <= S_RESULT;
          endcase
        end
        S_REPORT: begin
          if (drop) begin
            entry_valid[addr_q] <= 1'b0;
          end
          state <= S_RESULT;
        end
        S_DIVIDE: begin
          if (div_done) begin
            state <= S_ADJUST;
          end
        end
        S_ADJUST: begin
          state <= S_DECIDE;
        end
        S_DECIDE: begin
          if (want_defer && slots_in_use < SLOT_W'(POOL_SLOTS)) begin
            slots_in_use <= slots_in_use + 1'b1;
          end
          state <= S_RESULT;
        end
        S_RESULT: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Request latch, working values and result staging.
  always_ff @(posedge clk) begin
    if (s_xfer) begin
      mode_q     <= s_tuser;
      addr_q     <= AW'(s_tdata[3:0]);
      in_range_q <= 32'(s_tdata[3:0]) < NEIGHBORS;
      status_q   <= s_tdata[5:4];
      event_q    <= s_tdata[21:6];
      fine_q     <= s_tdata[37:22];
      coarse_q   <= s_tdata[69:38];
      deferred_q <= s_tdata[70];
    end
    unique case (state)
      S_READ: begin
        res_verdict  <= (mode_q == nwpt_pkg::MODE_REPORT && in_range_q
                         && status_q == nwpt_pkg::TX_ACKED) ?
                        nwpt_pkg::VERDICT_UPDATED : nwpt_pkg::VERDICT_UNKNOWN;
        res_defer    <= '0;
        res_expected <= '0;
        miss_entry   <= upd_entry;
        wait_q       <= (rd_entry.stamp - fine_q) & cyc_mask;
      end
      S_REPORT: begin
        res_verdict <= drop ? nwpt_pkg::VERDICT_DROPPED : nwpt_pkg::VERDICT_UPDATED;
      end
      S_DIVIDE: begin
        if (div_done) begin
          wait_q <= cycle_length - div_rem;
        end
      end
      S_ADJUST: begin
        if (wait_q < guard_ticks) begin
          wait_q <= wait_q + cycle_length;
        end
      end
      S_DECIDE: begin
        if (want_defer) begin
          if (slots_in_use < SLOT_W'(POOL_SLOTS)) begin
            res_verdict <= nwpt_pkg::VERDICT_DEFERRED;
            res_defer   <= coarse_ticks;
          end
        end else begin
          res_verdict  <= nwpt_pkg::VERDICT_SEND_NOW;
          res_expected <= fine_q + wait_q - guard_ticks;
        end
      end
      S_RESULT: begin
        if (out_free) begin
          m_tuser      <= res_verdict;
          out_defer    <= res_defer;
          out_expected <= res_expected;
        end
      end
      default: ;
    endcase
  end

  // The pool never holds more claims than it has slots.
  assert property (@(posedge clk) disable iff (rst)
    slots_in_use <= SLOT_W'(POOL_SLOTS))
    else $error("pool count above slot total");

  // The modulo unit only finishes while the sequencer waits for it.
  assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == S_DIVIDE)
    else $error("modulo result outside divide phase");

  // An accepted request always goes to the table read next.
  assert property (@(posedge clk) disable iff (rst)
    s_xfer |=> state == S_READ)
    else $error("accepted request skipped the table read");

  // A result is loaded only into a free output register.
  assert property (@(posedge clk) disable iff (rst)
    (state == S_RESULT && m_tvalid && !m_tready) |=> state == S_RESULT)
    else $error("result left while output was stalled");

endmodule

/* hw/rtl/nwpt_ram.sv */
module nwpt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* hw/rtl/nwpt_mod.sv */
module nwpt_mod (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [nwpt_pkg::FINE_BITS-1:0] dividend,
  input  logic [nwpt_pkg::FINE_BITS-1:0] divisor,
  output logic                          done,
  output logic [nwpt_pkg::FINE_BITS-1:0] remainder
);

  localparam int DW    = nwpt_pkg::FINE_BITS;
  localparam int CNT_W = $clog2(DW);

  logic [DW-1:0]    dq;
  logic [DW-1:0]    dvs;
  logic [CNT_W-1:0] count;
  logic             busy;
  logic [DW:0]      trial;
  logic [DW-1:0]    remainder_next;

  // Restoring step: bring down one dividend bit and subtract if it fits.
  always_comb begin
    trial = {remainder, dq[DW-1]};
    if (trial >= {1'b0, dvs}) begin
      remainder_next = DW'(trial - {1'b0, dvs});
    end else begin
      remainder_next = trial[DW-1:0];
    end
  end

  // One restoring step per cycle; done pulses after the last bit.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && count == CNT_W'(DW - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      remainder <= '0;
      dq        <= dividend;
      dvs       <= divisor;
      count     <= '0;
    end else if (busy) begin
      remainder <= remainder_next;
      dq        <= {dq[DW-2:0], 1'b0};
      count     <= count + 1'b1;
    end
  end

endmodule

/* verif/tb.sv */
`timescale 1ns / 100ps

module tb;
  import nwpt_pkg::*;

  // Codes the package leaves unnamed.
  localparam logic [STATUS_W-1:0] TX_OTHER      = 2'd2;
  localparam logic [STATUS_W-1:0] TX_RESERVED   = 2'd3;
  localparam logic [MODE_W-1:0]   MODE_RESERVED = 2'd3;

  localparam int          SETTLE_CYCLES = 40;
  localparam int          HOLD_OFF_CYCLES = 300;
  localparam int unsigned RUN_LIMIT = 400000;
  localparam int          N_DIRECTED = 23;

  typedef struct packed {
    logic [MODE_W-1:0]    mode;
    logic [INDEX_W-1:0]   idx;
    logic [STATUS_W-1:0]  status;
    logic [15:0]          event_time;
    logic [15:0]          fine_now;
    logic [COARSE_W-1:0]  coarse_now;
    logic                 deferred;
  } request_t;

  typedef struct packed {
    logic [VERDICT_W-1:0] verdict;
    logic [15:0]          defer_ticks;
    logic [15:0]          send_time;
  } outcome_t;

  // One directed row; when pinned is set the outcome is given by hand.
  typedef struct packed {
    request_t rq;
    logic     pinned;
    outcome_t want;
  } vector_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [S_DATA_W-1:0]    s_tdata = '0;
  logic [MODE_W-1:0]      s_tuser = '0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [M_DATA_W-1:0]    m_tdata;
  logic [VERDICT_W-1:0]   m_tuser;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  // Hand-written outcome travelling with the request on the input bus.
  logic     pinned_now = 1'b0;
  outcome_t pinned_want = '0;

  // Traffic shaping controls, written by the stimulus only.
  bit          calm = 1'b0;
  bit          hold_off_req = 1'b0;
  logic [31:0] coarse_clock;

  int unsigned cycle_count = 0;
  int          mismatch_count = 0;
  outcome_t    pending_outcomes [$];

  // Shadow of the configuration and the neighbor table.
  logic [15:0]        sh_cycle;
  logic [15:0]        sh_guard;
  logic [7:0]         sh_defer_thr;
  logic [COUNT_W-1:0] sh_noack_limit;
  logic [15:0]        sh_noack_window;
  logic               nb_valid [NEIGHBORS_DEF];
  logic [15:0]        nb_stamp [NEIGHBORS_DEF];
  logic [COUNT_W-1:0] nb_misses [NEIGHBORS_DEF];
  logic [31:0]        nb_win_start [NEIGHBORS_DEF];
  int                 pool_used;

  localparam vector_t DIRECTED_ROWS [N_DIRECTED] = '{
    // Empty table: queries and misses find nothing.
    '{'{MODE_QUERY, 0, TX_ACKED, 0, 0, 0, 0}, 1, '{VERDICT_UNKNOWN, 0, 0}},
    '{'{MODE_REPORT, 0, TX_NOACK, 0, 0, 0, 0}, 1, '{VERDICT_UNKNOWN, 0, 0}},
    '{'{MODE_REPORT, 0, TX_OTHER, 0, 0, 0, 0}, 1, '{VERDICT_UNKNOWN, 0, 0}},
    // Create entries at both ends of the fine timer.
    '{'{MODE_REPORT, 0, TX_ACKED, 0, 0, 0, 0}, 1, '{VERDICT_UPDATED, 0, 0}},
    '{'{MODE_REPORT, 15, TX_ACKED, 'hFFFF, 0, 0, 0}, 1, '{VERDICT_UPDATED, 0, 0}},
    // Wait under the guard adds a cycle, then defer or send now.
    '{'{MODE_QUERY, 0, TX_ACKED, 0, 0, 0, 0}, 1, '{VERDICT_DEFERRED, 15, 0}},
    '{'{MODE_QUERY, 0, TX_ACKED, 0, 0, 0, 1}, 1, '{VERDICT_SEND_NOW, 0, 4080}},
    '{'{MODE_QUERY, 15, TX_ACKED, 0, 'hFFFF, 0, 1}, 0, '{VERDICT_UNKNOWN, 0, 0}},
    '{'{MODE_QUERY, 0, TX_ACKED, 0, 4080, 0, 0}, 0, '{VERDICT_UNKNOWN, 0, 0}},
    // Releases, the second one on an empty pool.
    '{'{MODE_RELEASE, 0, TX_ACKED, 0, 0, 0, 0}, 1, '{VERDICT_UNKNOWN, 0, 0}},
    '{'{MODE_RELEASE, 0, TX_ACKED, 0, 0, 0, 0}, 1, '{VERDICT_UNKNOWN, 0, 0}},
    // Unused mode and unused status are ignored.
    '{'{MODE_RESERVED, 15, TX_RESERVED, 'hFFFF, 'hFFFF, 'hFFFF_FFFF, 1}, 1,
      '{VERDICT_UNKNOWN, 0, 0}},
    '{'{MODE_REPORT, 0, TX_RESERVED, 0, 0, 0, 0}, 1, '{VERDICT_UNKNOWN, 0, 0}},
    // Misses up to the limit, the window wrapping through zero.
    '{'{MODE_REPORT, 3, TX_ACKED, 'h1234, 0, 0, 0}, 1, '{VERDICT_UPDATED, 0, 0}},
    '{'{MODE_REPORT, 3, TX_NOACK, 0, 0, 'hFFFF_FFF0, 0}, 1, '{VERDICT_UPDATED, 0, 0}},
    '{'{MODE_REPORT, 3, TX_NOACK, 0, 0, 'h10, 0}, 1, '{VERDICT_UPDATED, 0, 0}},
    '{'{MODE_REPORT, 3, TX_NOACK, 0, 0, 'h20, 0}, 1, '{VERDICT_UPDATED, 0, 0}},
    '{'{MODE_REPORT, 3, TX_NOACK, 0, 0, 'h30, 0}, 1, '{VERDICT_DROPPED, 0, 0}},
    '{'{MODE_REPORT, 3, TX_NOACK, 0, 0, 'h40, 0}, 1, '{VERDICT_UNKNOWN, 0, 0}},
    // Window boundary: one tick short, then exactly expired.
    '{'{MODE_REPORT, 5, TX_ACKED, 'h8000, 0, 0, 0}, 1, '{VERDICT_UPDATED, 0, 0}},
    '{'{MODE_REPORT, 5, TX_NOACK, 0, 0, 1000, 0}, 1, '{VERDICT_UPDATED, 0, 0}},
    '{'{MODE_REPORT, 5, TX_NOACK, 0, 0, 8679, 0}, 1, '{VERDICT_UPDATED, 0, 0}},
    '{'{MODE_REPORT, 5, TX_NOACK, 0, 0, 8680, 0}, 1, '{VERDICT_DROPPED, 0, 0}}
  };

  neighbor_wakeup_phase_table_unit uut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // 100 MHz clock.
  initial begin
    forever #5 clk = ~clk;
  end

  // Run limit.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == RUN_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  task automatic flag_mismatch(string field, int unsigned got, int unsigned want);
    $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h", $time, field, got, want);
    mismatch_count++;
  endtask

  // Applies one request to the shadow table and returns the outcome it should give.
  function automatic outcome_t phase_table_step(request_t rq);
    outcome_t    o;
    logic [15:0] cyc;
    logic [15:0] lead;
    logic [15:0] rest;
    logic [31:0] coarse;
    o = '0;
    if (rq.mode == MODE_RELEASE) begin
      if (pool_used > 0) pool_used--;
    end else if (rq.mode == MODE_REPORT) begin
      if (rq.status == TX_ACKED) begin
        nb_valid[rq.idx] = 1'b1;
        nb_stamp[rq.idx] = rq.event_time;
        nb_misses[rq.idx] = '0;
        o.verdict = VERDICT_UPDATED;
      end else if (rq.status == TX_NOACK && nb_valid[rq.idx]) begin
        if (nb_misses[rq.idx] != COUNT_MAX) nb_misses[rq.idx]++;
        if (nb_misses[rq.idx] == 3'd1) nb_win_start[rq.idx] = rq.coarse_now;
        if (nb_misses[rq.idx] >= sh_noack_limit ||
            (rq.coarse_now - nb_win_start[rq.idx]) >= {16'd0, sh_noack_window}) begin
          nb_valid[rq.idx] = 1'b0;
          o.verdict = VERDICT_DROPPED;
        end else begin
          o.verdict = VERDICT_UPDATED;
        end
      end
    end else if (rq.mode == MODE_QUERY && nb_valid[rq.idx]) begin
      // Wait to the next wake-up: a mask when the cycle length is a power of two, else a modulo.
      cyc = sh_cycle;
      if ((cyc & (cyc - 16'd1)) == 16'd0)
        lead = (nb_stamp[rq.idx] - rq.fine_now) & (cyc - 16'd1);
      else
        lead = cyc - ((rq.fine_now - nb_stamp[rq.idx]) % cyc);
      if (lead < sh_guard) lead = lead + cyc;
      rest = (lead >= sh_guard) ? lead - sh_guard : 16'd0;
      coarse = (32'(COARSE_RATE) * {16'd0, rest}) / 32'(FINE_RATE);
      if (coarse > 32'hFFFF) coarse = 32'hFFFF;
      if (coarse > {24'd0, sh_defer_thr} && !rq.deferred) begin
        if (pool_used < POOL_SLOTS_DEF) begin
          pool_used++;
          o.verdict = VERDICT_DEFERRED;
          o.defer_ticks = coarse[15:0];
        end
      end else begin
        o.verdict = VERDICT_SEND_NOW;
        o.send_time = rq.fine_now + lead - sh_guard;
      end
    end
    return o;
  endfunction

  // Watch the request and configuration channels and keep the shadow in step.
  always @(posedge clk) begin
    request_t seen;
    outcome_t calc;
    if (rst) begin
      sh_cycle = CYCLE_LENGTH_RST;
      sh_guard = GUARD_TICKS_RST;
      sh_defer_thr = DEFER_THRESHOLD_RST;
      sh_noack_limit = NOACK_LIMIT_RST;
      sh_noack_window = NOACK_WINDOW_RST;
      for (int n = 0; n < NEIGHBORS_DEF; n++) nb_valid[n] = 1'b0;
      pool_used = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_CYCLE_LENGTH:    sh_cycle = cfg_data;
          REG_GUARD_TICKS:     sh_guard = cfg_data;
          REG_DEFER_THRESHOLD: sh_defer_thr = cfg_data[7:0];
          REG_NOACK_LIMIT:     sh_noack_limit = cfg_data[COUNT_W-1:0];
          REG_NOACK_WINDOW:    sh_noack_window = cfg_data;
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) begin
        seen.mode = s_tuser;
        seen.idx = s_tdata[3:0];
        seen.status = s_tdata[5:4];
        seen.event_time = s_tdata[21:6];
        seen.fine_now = s_tdata[37:22];
        seen.coarse_now = s_tdata[69:38];
        seen.deferred = s_tdata[70];
        calc = phase_table_step(seen);
        pending_outcomes.push_back(pinned_now ? pinned_want : calc);
      end
    end
  end

  // Check every result transfer against the oldest pending outcome.
  always @(posedge clk) begin
    outcome_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_outcomes.size() == 0) begin
        flag_mismatch("unexpected result verdict", m_tuser, 0);
      end else begin
        want = pending_outcomes.pop_front();
        if (m_tuser != want.verdict)
          flag_mismatch("verdict", m_tuser, want.verdict);
        if (m_tdata[15:0] != want.defer_ticks)
          flag_mismatch("defer_ticks", m_tdata[15:0], want.defer_ticks);
        if (m_tdata[31:16] != want.send_time)
          flag_mismatch("expected_time", m_tdata[31:16], want.send_time);
      end
    end
  end

  // Result receiver: random stalls, one long hold-off on request.
  initial begin : result_sink
    int hold_left = 0;
    bit hold_used = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_req && !hold_used) begin
        hold_used = 1'b1;
        hold_left = HOLD_OFF_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else if (calm) begin
        m_tready <= 1'b1;
      end else begin
        m_tready <= ($urandom_range(99) >= 19);
      end
    end
  end

  // Offer one request and return at the edge where it transfers.
  task automatic offer_request(request_t rq, logic pinned, outcome_t want);
    if (!calm) begin
      while ($urandom_range(99) < 19) begin
        s_tvalid <= 1'b0;
        @(posedge clk);
      end
    end
    s_tvalid <= 1'b1;
    s_tdata <= {1'b0, rq.deferred, rq.coarse_now, rq.fine_now, rq.event_time,
                rq.status, rq.idx};
    s_tuser <= rq.mode;
    pinned_now <= pinned;
    pinned_want <= want;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  // Stop offering and wait until every outstanding result has come back.
  task automatic drain_results();
    s_tvalid <= 1'b0;
    pinned_now <= 1'b0;
    @(posedge clk);
    while (pending_outcomes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write all five registers; only called with nothing in flight.
  task automatic load_settings(logic [15:0] cycle_len, logic [15:0] guard,
                               logic [7:0] thr, logic [COUNT_W-1:0] limit,
                               logic [15:0] window);
    logic [CFG_INDEX_W-1:0] regs [5];
    logic [15:0]            vals [5];
    regs = '{REG_CYCLE_LENGTH, REG_GUARD_TICKS, REG_DEFER_THRESHOLD,
             REG_NOACK_LIMIT, REG_NOACK_WINDOW};
    vals = '{cycle_len, guard, {8'd0, thr}, {13'd0, limit}, window};
    for (int r = 0; r < 5; r++) begin
      cfg_valid <= 1'b1;
      cfg_index <= regs[r];
      cfg_data <= vals[r];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
    end
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Random traffic, mostly on a few neighbors so miss runs and deferrals build up.
  task automatic run_traffic(int count, int unsigned coarse_step);
    request_t    rq;
    int unsigned pick;
    for (int k = 0; k < count; k++) begin
      pick = $urandom_range(99);
      rq.mode = (pick < 42) ? MODE_REPORT : (pick < 82) ? MODE_QUERY :
                (pick < 97) ? MODE_RELEASE : MODE_RESERVED;
      rq.idx = ($urandom_range(99) < 70) ? INDEX_W'($urandom_range(3)) :
                                           INDEX_W'($urandom_range(15));
      pick = $urandom_range(99);
      rq.status = (pick < 45) ? TX_ACKED : (pick < 88) ? TX_NOACK :
                  (pick < 96) ? TX_OTHER : TX_RESERVED;
      rq.event_time = 16'($urandom);
      rq.fine_now = 16'($urandom);
      coarse_clock = coarse_clock + $urandom_range(coarse_step);
      rq.coarse_now = ($urandom_range(99) < 5) ? $urandom : coarse_clock;
      rq.deferred = ($urandom_range(99) < 30);
      offer_request(rq, 1'b0, '0);
    end
  endtask

  initial begin : stimulus
    coarse_clock = $urandom;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed rows at the reset settings.
    for (int k = 0; k < N_DIRECTED; k++)
      offer_request(DIRECTED_ROWS[k].rq, DIRECTED_ROWS[k].pinned, DIRECTED_ROWS[k].want);
    run_traffic(150, 100);
    drain_results();

    // Cycle length that is not a power of two, no guard, every miss drops; no idling on either side.
    calm = 1'b1;
    load_settings(16'd3000, 16'd0, 8'd0, 3'd1, 16'd1);
    run_traffic(150, 3);
    drain_results();
    calm = 1'b0;

    // Upper extremes; the receiver holds off so the block backs up.
    load_settings(16'hFFFF, 16'hFFFF, 8'hFF, 3'd7, 16'hFFFF);
    hold_off_req = 1'b1;
    run_traffic(150, 2000);
    drain_results();

    // Zero cycle length and zero miss limit.
    load_settings(16'd0, 16'd100, 8'd10, 3'd0, 16'd200);
    run_traffic(150, 20);
    drain_results();

    // Random settings; the cycle length is a power of two half the time.
    load_settings($urandom_range(1) ? 16'(1 << $urandom_range(15)) :
                                      16'($urandom_range(65535, 1)),
                  16'($urandom_range(512)), 8'($urandom_range(40)),
                  COUNT_W'($urandom_range(7, 1)), 16'($urandom_range(2000, 1)));
    run_traffic(150, 50);
    drain_results();

    // Single-tick cycle.
    load_settings(16'd1, 16'd3, 8'd0, 3'd3, 16'hFFFF);
    run_traffic(80, 10);
    drain_results();

    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

/* files.f */
hw/rtl/nwpt_pkg.sv
hw/rtl/nwpt_ram.sv
hw/rtl/nwpt_mod.sv
hw/rtl/neighbor_wakeup_phase_table_unit.sv
verif/tb.sv
